// ===== rtl/tr7s_pkg.sv =====
// Shared types, constants and the segment decode for the temperature display block.
// No dependencies; imported by every module in rtl/.
`default_nettype none

package tr7s_pkg;

  localparam int unsigned RawW   = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned SegW   = 8;
  localparam int unsigned LimitW = 3;

  localparam logic [RawW-1:0]   FailMark     = 16'hFFFF;
  localparam logic [RawW-1:0]   HundredSixt  = 16'd1600;
  localparam logic [SegW-1:0]   DotSegment   = 8'h80;
  localparam logic [SegW-1:0]   BlankSegment = 8'h00;

  localparam logic [LimitW-1:0] ErrorLimitRst   = 3'd5;
  localparam logic [WordW-1:0]  ErrorPatternRst = 32'h7950_5000;
  localparam logic [SegW-1:0]   MinusPatternRst = 8'h40;

  // Register index on the configuration port
  typedef enum logic [1:0] {
    CFG_ERROR_LIMIT   = 2'd0,
    CFG_ERROR_PATTERN = 2'd1,
    CFG_MINUS_PATTERN = 2'd2
  } cfg_idx_e;

  // Fail tracker view of the item in the input register
  typedef struct packed {
    logic fault_next;  // count at or above limit after this reading
    logic show_error;  // load error pattern into the display word
  } fail_status_t;

  // Standard hex seven-segment decode
  function automatic logic [SegW-1:0] seg_lut(input logic [3:0] digit);
    logic [SegW-1:0] seg;
    case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h77;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h39;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h79;
      4'hF: seg = 8'h71;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tr7s_word_build.sv =====
// Combinational decode of one raw reading into the four segment bytes.
// Depends on tr7s_pkg.
`default_nettype none

module tr7s_word_build (
  input  wire logic [tr7s_pkg::RawW-1:0]  raw_i,
  input  wire logic [tr7s_pkg::SegW-1:0]  minus_pattern_i,
  output      logic [tr7s_pkg::WordW-1:0] word_o
);
  import tr7s_pkg::*;

  logic            neg;
  logic            over_hundred;
  logic [15:0]     mag;
  logic [10:0]     mag_hi;     // mag / 32
  logic [22:0]     q_prod;
  logic [8:0]      q5;         // mag / 160
  logic [10:0]     q5_times5;
  logic [10:0]     r5_full;
  logic [2:0]      r5;         // (mag / 32) % 5
  logic [3:0]      tens;
  logic [3:0]      units;
  logic [6:0]      frac_x5;
  logic [3:0]      tenths;
  logic [SegW-1:0] lead;

  always_comb begin
    neg          = raw_i[15];
    over_hundred = !neg && (raw_i >= HundredSixt);
    if (neg) begin
      mag = 16'(~raw_i + 16'd1);  // 0x8000 maps to 32768
    end else if (over_hundred) begin
      mag = raw_i - HundredSixt;
    end else begin
      mag = raw_i;
    end

    // 160 = 32 * 5: divide by 5 via reciprocal, exact for mag_hi <= 1024
    mag_hi    = mag[15:5];
    q_prod    = 23'(mag_hi) * 23'd3277;
    q5        = q_prod[22:14];
    q5_times5 = {q5, 2'b00} + 11'(q5);
    r5_full   = mag_hi - q5_times5;
    r5        = r5_full[2:0];

    tens    = (q5 > 9'd15) ? 4'hF : q5[3:0];
    units   = {r5, mag[4]};
    frac_x5 = 7'(mag[3:0]) * 7'd5;
    tenths  = frac_x5[6:3];

    if (neg) begin
      lead = minus_pattern_i;
    end else if (over_hundred) begin
      lead = seg_lut(4'h1);
    end else begin
      lead = BlankSegment;
    end

    word_o = {lead, seg_lut(tens), seg_lut(units) | DotSegment, seg_lut(tenths)};
  end

endmodule

`default_nettype wire

// ===== rtl/tr7s_fail_ctrl.sv =====
// Saturating count of failed sensor reads and the fault decision.
// Depends on tr7s_pkg.
`default_nettype none

module tr7s_fail_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        advance_i,
  input  wire logic                        is_fail_i,
  input  wire logic [tr7s_pkg::LimitW-1:0] error_limit_i,
  output      tr7s_pkg::fail_status_t      status_o
);
  import tr7s_pkg::*;

  logic [LimitW-1:0] count_q, count_d;
  logic [LimitW-1:0] limit_eff;

  always_comb begin
    limit_eff = (error_limit_i == '0) ? LimitW'(1) : error_limit_i;
    if (!is_fail_i) begin
      count_d = '0;
    end else if (count_q < limit_eff) begin
      count_d = count_q + LimitW'(1);
    end else begin
      count_d = count_q;  // saturated; a lowered limit leaves it as is
    end
    status_o.fault_next = (count_d >= limit_eff);
    status_o.show_error = is_fail_i && status_o.fault_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/temp_reading_to_seven_segment.sv =====
// Top level: raw sensor reading in, seven-segment display word out.
// Depends on tr7s_pkg, tr7s_word_build, tr7s_fail_ctrl.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o) carries one raw reading per
//    transfer: raw_high_i:raw_low_i, two's complement sixteenths of a degree.
//    0xFFFF means the sensor read failed.
//  - Output channel (out_valid_o / out_stall_i) carries exactly one result per
//    reading: display word, last good temperature and the fault flag.
//  - A reading moves from the input register into the output register when
//    the output is free; out_valid_o stays high until it is taken.
//  - Throughput: one reading per clock through a two-stage pipe, unless
//    stalled; single-pass decode (11x12 multiply for /160, segment lookups).
//  - Fail count, shown word and last temperature change only when a reading
//    moves into the output register, so readings are applied in order.
//  - With a result stalled, one more reading fits in the input register;
//    in_stall_o rises only when both stages are full.
//  - Reset clears the pipe and state and loads the register defaults.
//  - Configuration writes (cfg_we_i) take effect at the next edge and are
//    meant for when no reading is in flight.
`default_nettype none

module temp_reading_to_seven_segment (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration write port
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [tr7s_pkg::WordW-1:0] cfg_data_i,
  // input channel
  input  wire logic                       in_valid_i,
  output      logic                       in_stall_o,
  input  wire logic [7:0]                 raw_low_i,
  input  wire logic [7:0]                 raw_high_i,
  // output channel
  output      logic                       out_valid_o,
  input  wire logic                       out_stall_i,
  output      logic [tr7s_pkg::WordW-1:0] display_word_o,
  output      logic signed [15:0]         temp_sixteenths_o,
  output      logic                       sensor_fault_o
);
  import tr7s_pkg::*;

  // configuration registers
  logic [LimitW-1:0] error_limit_q;
  logic [WordW-1:0]  error_pattern_q;
  logic [SegW-1:0]   minus_pattern_q;

  // input stage
  logic              s1_valid_q, s1_valid_d;
  logic [RawW-1:0]   raw_q;

  // output stage, doubles as the block state
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  shown_word_q, shown_word_d;
  logic [RawW-1:0]   last_temp_q, last_temp_d;
  logic              fault_q;

  logic              in_accept;
  logic              advance;    // input stage moves into output stage
  logic              is_fail;
  logic [WordW-1:0]  built_word;
  fail_status_t      fail_status;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_limit_q   <= ErrorLimitRst;
      error_pattern_q <= ErrorPatternRst;
      minus_pattern_q <= MinusPatternRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ERROR_LIMIT:   error_limit_q   <= cfg_data_i[LimitW-1:0];
        CFG_ERROR_PATTERN: error_pattern_q <= cfg_data_i;
        CFG_MINUS_PATTERN: minus_pattern_q <= cfg_data_i[SegW-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // pipe control
  always_comb begin
    advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
    in_stall_o  = s1_valid_q && !advance;
    in_accept   = in_valid_i && !in_stall_o;
    s1_valid_d  = in_accept || (s1_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      raw_q <= {raw_high_i, raw_low_i};
    end
  end

  assign is_fail = (raw_q == FailMark);

  tr7s_word_build u_word_build (
    .raw_i           (raw_q),
    .minus_pattern_i (minus_pattern_q),
    .word_o          (built_word)
  );

  tr7s_fail_ctrl u_fail_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .is_fail_i     (is_fail),
    .error_limit_i (error_limit_q),
    .status_o      (fail_status)
  );

  // next display state: failed reads below the limit keep the old word
  always_comb begin
    shown_word_d = shown_word_q;
    last_temp_d  = last_temp_q;
    if (!is_fail) begin
      shown_word_d = built_word;
      last_temp_d  = raw_q;
    end else if (fail_status.show_error) begin
      shown_word_d = error_pattern_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_word_q <= '0;
      last_temp_q  <= '0;
      fault_q      <= 1'b0;
    end else if (advance) begin
      shown_word_q <= shown_word_d;
      last_temp_q  <= last_temp_d;
      fault_q      <= fail_status.fault_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign display_word_o    = shown_word_q;
  assign temp_sixteenths_o = signed'(last_temp_q);
  assign sensor_fault_o    = fault_q;

endmodule

`default_nettype wire
